// ===== rtl/core/tvs_pkg.sv =====
// shared types and codes for the trapezoid variate sampler
// no dependencies; imported by every module of the block but tvs_fifo
package tvs_pkg;

  // operation codes on the input side
  localparam logic OP_DRAW    = 1'b0;
  localparam logic OP_DENSITY = 1'b1;

  // region codes on the result side
  localparam logic [1:0] REG_OUTSIDE = 2'd0;
  localparam logic [1:0] REG_RISE    = 2'd1;
  localparam logic [1:0] REG_PLATEAU = 2'd2;
  localparam logic [1:0] REG_FALL    = 2'd3;

  typedef enum logic [1:0] {
    IDX_CORNER_LOW,
    IDX_CORNER_RISE_END,
    IDX_CORNER_FALL_START,
    IDX_CORNER_HIGH
  } reg_index_t;

  // what the front end decided about one item
  typedef enum logic [2:0] {
    K_BAD,
    K_ZERO,
    K_S_RISE,
    K_S_PLAT,
    K_S_FALL,
    K_D_RISE,
    K_D_PLAT,
    K_D_FALL
  } kind_t;

  typedef struct packed {
    logic busy;
    logic ordered;
  } cfg_status_t;

  function automatic logic is_draw(kind_t k);
    return (k == K_S_RISE) || (k == K_S_PLAT) || (k == K_S_FALL);
  endfunction

endpackage

// ===== rtl/core/trapezoid_variate_sampler_unit.sv =====
// trapezoid variate sampler, top level: one item in, one result out per cycle unless stalled
// throughput: one item per cycle while full is low; the back end stalls only when the result queue is full
// after reset and after every configuration write, full stays high while the derived
// constants are recomputed, by a bit-serial divider when the corners are ordered and the span is nonzero
// depends on tvs_pkg, tvs_fifo, tvs_derive, tvs_front, tvs_back
module trapezoid_variate_sampler_unit import tvs_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation,
  input  logic [31:0]                   uniform_fraction,
  input  logic signed [VALUE_WIDTH-1:0] query_point,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [VALUE_WIDTH-1:0] result_value,
  output logic [1:0]                    region,
  output logic                          corners_bad,
  input  logic                          write_enable,
  input  logic [1:0]                    register_index,
  input  logic [VALUE_WIDTH-1:0]        write_data
);
  localparam int V  = VALUE_WIDTH;
  localparam int XW = (V > 33) ? V : 33;
  localparam int MW = 3 + XW;
  localparam int OW = V + 3;

  logic signed [V-1:0] corner_a;
  logic signed [V-1:0] corner_b;
  logic signed [V-1:0] corner_c;
  logic signed [V-1:0] corner_d;
  logic [V-1:0]        rise;
  logic [V-1:0]        fall;
  logic [V:0]          span;
  logic [V-2:0]        height;
  logic [32:0]         low_thr;
  logic [32:0]         high_thr;
  cfg_status_t         status;

  kind_t               f_kind;
  logic [XW-1:0]       f_xop;
  logic                mid_full;
  logic                mid_empty;
  logic                mid_pop;
  logic [MW-1:0]       mid_data;

  logic                out_full;
  logic                out_push;
  logic [V-1:0]        b_value;
  logic [1:0]          b_region;
  logic                b_bad;
  logic [OW-1:0]       out_data;

  assign full = mid_full || status.busy;

  tvs_derive #(.VALUE_WIDTH(V), .FRAC_BITS(FRAC_BITS)) u_derive (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data),
    .corner_a       (corner_a),
    .corner_b       (corner_b),
    .corner_c       (corner_c),
    .corner_d       (corner_d),
    .rise           (rise),
    .fall           (fall),
    .span           (span),
    .height         (height),
    .low_thr        (low_thr),
    .high_thr       (high_thr),
    .status         (status)
  );

  tvs_front #(.VALUE_WIDTH(V)) u_front (
    .operation        (operation),
    .uniform_fraction (uniform_fraction),
    .query_point      (query_point),
    .corner_a         (corner_a),
    .corner_b         (corner_b),
    .corner_c         (corner_c),
    .corner_d         (corner_d),
    .low_thr          (low_thr),
    .high_thr         (high_thr),
    .ordered          (status.ordered),
    .kind             (f_kind),
    .xop              (f_xop)
  );

  tvs_fifo #(.WIDTH(MW), .DEPTH(4)) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (push && !full),
    .wdata ({f_kind, f_xop}),
    .full  (mid_full),
    .rd    (mid_pop),
    .rdata (mid_data),
    .empty (mid_empty)
  );

  tvs_back #(.VALUE_WIDTH(V)) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!mid_empty),
    .in_pop     (mid_pop),
    .in_kind    (kind_t'(mid_data[MW-1 -: 3])),
    .in_xop     (mid_data[XW-1:0]),
    .corner_a   (corner_a),
    .corner_d   (corner_d),
    .rise       (rise),
    .fall       (fall),
    .span       (span),
    .height     (height),
    .out_full   (out_full),
    .out_push   (out_push),
    .out_value  (b_value),
    .out_region (b_region),
    .out_bad    (b_bad)
  );

  tvs_fifo #(.WIDTH(OW), .DEPTH(2)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_push),
    .wdata ({b_value, b_region, b_bad}),
    .full  (out_full),
    .rd    (pop),
    .rdata (out_data),
    .empty (empty)
  );

  assign result_value = out_data[OW-1 -: V];
  assign region       = out_data[2:1];
  assign corners_bad  = out_data[0];
endmodule

// ===== rtl/core/tvs_fifo.sv =====
// small register queue used between stages and on the result side
// depends on nothing
module tvs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             wr_en;
  logic             rd_en;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = wr && !full;
  assign rd_en = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

// ===== rtl/core/tvs_derive.sv =====
// corner registers and the derived constants, with a bit-serial divider
// depends on tvs_pkg
module tvs_derive import tvs_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [1:0]                    register_index,
  input  logic [VALUE_WIDTH-1:0]        write_data,
  output logic signed [VALUE_WIDTH-1:0] corner_a,
  output logic signed [VALUE_WIDTH-1:0] corner_b,
  output logic signed [VALUE_WIDTH-1:0] corner_c,
  output logic signed [VALUE_WIDTH-1:0] corner_d,
  output logic [VALUE_WIDTH-1:0]        rise,
  output logic [VALUE_WIDTH-1:0]        fall,
  output logic [VALUE_WIDTH:0]          span,
  output logic [VALUE_WIDTH-2:0]        height,
  output logic [32:0]                   low_thr,
  output logic [32:0]                   high_thr,
  output cfg_status_t                   status
);
  localparam int V    = VALUE_WIDTH;
  localparam int SW   = V + 1;
  localparam int DW_A = 2 * FRAC_BITS + 2;
  localparam int DW_B = SW + 33;
  localparam int DW   = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int CW   = $clog2(DW + 1);
  localparam logic [V-1:0] RST_A = '0;
  localparam logic [V-1:0] RST_B = V'(64'd1 << (FRAC_BITS - 2));
  localparam logic [V-1:0] RST_C = V'(64'd3 << (FRAC_BITS - 2));
  localparam logic [V-1:0] RST_D = V'(64'd1 << FRAC_BITS);
  localparam logic [32:0]  ONE32 = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_H,
    ST_DIV_LO,
    ST_DIV_HI
  } state_t;

  state_t          state;
  logic            ordered;
  logic [DW-1:0]   dvd;
  logic [DW-1:0]   quot;
  logic [SW-1:0]   rem;
  logic [CW-1:0]   cnt;

  logic signed [V:0] d_ba;
  logic signed [V:0] d_cb;
  logic signed [V:0] d_dc;
  logic              ordered_c;
  logic [SW-1:0]     span_c;
  logic [SW:0]       rs;
  logic              ge;
  logic [SW-1:0]     rem_step;
  logic [DW-1:0]     quot_step;

  always_comb begin
    d_ba      = {corner_b[V-1], corner_b} - {corner_a[V-1], corner_a};
    d_cb      = {corner_c[V-1], corner_c} - {corner_b[V-1], corner_b};
    d_dc      = {corner_d[V-1], corner_d} - {corner_c[V-1], corner_c};
    ordered_c = (corner_a <= corner_b) && (corner_b <= corner_c) && (corner_c <= corner_d);
    span_c    = SW'(d_ba[V-1:0]) + SW'(d_dc[V-1:0]) + (SW'(d_cb[V-1:0]) << 1);
    rs        = {rem, dvd[DW-1]};
    ge        = (rs >= {1'b0, span});
    rem_step  = ge ? SW'(rs - {1'b0, span}) : rs[SW-1:0];
    quot_step = {quot[DW-2:0], ge};
  end

  assign status.busy    = (state != ST_IDLE);
  assign status.ordered = ordered;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_PREP;
      ordered  <= 1'b1;
      corner_a <= RST_A;
      corner_b <= RST_B;
      corner_c <= RST_C;
      corner_d <= RST_D;
      cnt      <= '0;
    end else if (write_enable) begin
      unique case (reg_index_t'(register_index))
        IDX_CORNER_LOW:        corner_a <= write_data;
        IDX_CORNER_RISE_END:   corner_b <= write_data;
        IDX_CORNER_FALL_START: corner_c <= write_data;
        IDX_CORNER_HIGH:       corner_d <= write_data;
      endcase
      state <= ST_PREP;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        ST_PREP: begin
          ordered <= ordered_c;
          rise    <= d_ba[V-1:0];
          fall    <= d_dc[V-1:0];
          span    <= span_c;
          if (!ordered_c) begin
            height   <= '0;
            low_thr  <= '0;
            high_thr <= '0;
            state    <= ST_IDLE;
          end else if (span_c == '0) begin
            height   <= '1;
            low_thr  <= '0;
            high_thr <= ONE32;
            state    <= ST_IDLE;
          end else begin
            dvd   <= DW'(1) << (2 * FRAC_BITS + 1);
            rem   <= '0;
            quot  <= '0;
            cnt   <= CW'(DW);
            state <= ST_DIV_H;
          end
        end
        ST_DIV_H, ST_DIV_LO, ST_DIV_HI: begin
          if (cnt != '0) begin
            dvd  <= dvd << 1;
            rem  <= rem_step;
            quot <= quot_step;
            cnt  <= cnt - 1'b1;
          end else begin
            rem  <= '0;
            quot <= '0;
            cnt  <= CW'(DW);
            if (state == ST_DIV_H) begin
              // saturate the plateau height to the largest positive value
              height <= (quot > DW'({(V-1){1'b1}})) ? '1 : quot[V-2:0];
              dvd    <= DW'(rise) << 32;
              state  <= ST_DIV_LO;
            end else if (state == ST_DIV_LO) begin
              low_thr <= quot[32:0];
              dvd     <= DW'(span - SW'(fall)) << 32;
              state   <= ST_DIV_HI;
            end else begin
              high_thr <= quot[32:0];
              state    <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/tvs_front.sv =====
// front end: sorts each item into a region and picks the first multiplicand
// depends on tvs_pkg
module tvs_front import tvs_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          operation,
  input  logic [31:0]                   uniform_fraction,
  input  logic signed [VALUE_WIDTH-1:0] query_point,
  input  logic signed [VALUE_WIDTH-1:0] corner_a,
  input  logic signed [VALUE_WIDTH-1:0] corner_b,
  input  logic signed [VALUE_WIDTH-1:0] corner_c,
  input  logic signed [VALUE_WIDTH-1:0] corner_d,
  input  logic [32:0]                   low_thr,
  input  logic [32:0]                   high_thr,
  input  logic                          ordered,
  output kind_t                         kind,
  output logic [((VALUE_WIDTH > 33) ? VALUE_WIDTH : 33)-1:0] xop
);
  localparam int V  = VALUE_WIDTH;
  localparam int XW = (V > 33) ? V : 33;

  logic [32:0]       u33;
  logic [32:0]       u_rev;
  logic signed [V:0] xa;
  logic signed [V:0] dx;

  always_comb begin
    u33   = {1'b0, uniform_fraction};
    u_rev = 33'h1_0000_0000 - u33;
    xa    = {query_point[V-1], query_point} - {corner_a[V-1], corner_a};
    dx    = {corner_d[V-1], corner_d} - {query_point[V-1], query_point};
    kind  = K_BAD;
    xop   = '0;
    if (!ordered) begin
      kind = K_BAD;
    end else if (operation == OP_DRAW) begin
      if (u33 < low_thr) begin
        kind = K_S_RISE;
        xop  = XW'(u33);
      end else if (u33 < high_thr) begin
        kind = K_S_PLAT;
        xop  = XW'(u33);
      end else begin
        kind = K_S_FALL;
        xop  = XW'(u_rev);
      end
    end else begin
      if (query_point < corner_a) begin
        kind = K_ZERO;
      end else if (query_point < corner_b) begin
        kind = K_D_RISE;
        xop  = XW'(xa[V-1:0]);
      end else if (query_point < corner_c) begin
        kind = K_D_PLAT;
      end else if (query_point < corner_d) begin
        kind = K_D_FALL;
        xop  = XW'(dx[V-1:0]);
      end else begin
        kind = K_ZERO;
      end
    end
  end
endmodule

// ===== rtl/core/tvs_back.sv =====
// back end: two split multiplies, then a shared root/quotient pipeline
// of one bit per stage, then the final result select
// depends on tvs_pkg
module tvs_back import tvs_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_pop,
  input  kind_t                         in_kind,
  input  logic [((VALUE_WIDTH > 33) ? VALUE_WIDTH : 33)-1:0] in_xop,
  input  logic signed [VALUE_WIDTH-1:0] corner_a,
  input  logic signed [VALUE_WIDTH-1:0] corner_d,
  input  logic [VALUE_WIDTH-1:0]        rise,
  input  logic [VALUE_WIDTH-1:0]        fall,
  input  logic [VALUE_WIDTH:0]          span,
  input  logic [VALUE_WIDTH-2:0]        height,
  input  logic                          out_full,
  output logic                          out_push,
  output logic [VALUE_WIDTH-1:0]        out_value,
  output logic [1:0]                    out_region,
  output logic                          out_bad
);
  localparam int V   = VALUE_WIDTH;
  localparam int SW  = V + 1;
  localparam int XW  = (V > 33) ? V : 33;
  localparam int H   = XW / 2;
  localparam int YW  = V + 1;
  localparam int PR  = XW + YW;
  localparam int QH  = (SW + 1) / 2;
  localparam int PW  = 2 * V + 2;
  localparam int RW  = V + 1;
  localparam int RMW = V + 3;

  logic adv;

  // stage 1: partial products of the first multiply
  logic             v1;
  kind_t            k1;
  logic [H+YW-1:0]  pl1;
  logic [XW-H+YW-1:0] ph1;
  logic [YW-1:0]    y1;
  // stage 2: first product
  logic             v2;
  kind_t            k2;
  logic [PR-1:0]    pr2;
  // stage 3: partial products of the second multiply
  logic             v3;
  kind_t            k3;
  logic [PR-1:0]    pr3;
  logic [V+QH-1:0]  p2l;
  logic [V+SW-QH-1:0] p2h;
  logic [SW-1:0]    q2;
  logic [V-1:0]     scale2;

  // root pipeline, index 0 is loaded from stage 3
  logic [RW:0]      sv;
  kind_t            sk   [RW+1];
  logic [V-1:0]     saux [RW+1];
  logic [PW-1:0]    ssrc [RW+1];
  logic [RMW-1:0]   srem [RW+1];
  logic [RW-1:0]    sroot[RW+1];
  logic [PW-1:0]    nsrc [RW];
  logic [RMW-1:0]   nrem [RW];
  logic [RW-1:0]    nroot[RW];

  // stage 0 load values
  logic [SW-1:0]    q3;
  logic [PW-1:0]    prod_p;
  logic [V-1:0]     dma;
  logic [V+1:0]     half_sum;
  logic [V:0]       half;
  logic [V-1:0]     aux0;
  logic [PW-1:0]    src0;
  logic [RMW-1:0]   rem0;

  // final select
  logic [V-1:0]     off_r;
  logic [V-1:0]     off_f;

  assign adv    = !out_full || !sv[RW];
  assign in_pop = adv && in_valid;
  assign y1     = is_draw(in_kind) ? span : YW'(height);
  assign q2     = pr2[32 +: SW];
  assign scale2 = (k2 == K_S_FALL) ? fall : rise;

  always_comb begin
    q3       = pr3[32 +: SW];
    prod_p   = PW'(p2l) + (PW'(p2h) << QH);
    dma      = V'(corner_d - corner_a);
    half_sum = (V+2)'(rise) + (V+2)'(q3);
    half     = half_sum[V+1:1];
    aux0     = (half > {1'b0, dma}) ? dma : half[V-1:0];
    if (is_draw(k3)) begin
      src0 = prod_p;
      rem0 = '0;
    end else begin
      // long division: quotient fits RW bits, so start from the top part
      src0 = {pr3[V:0], {(V+1){1'b0}}};
      rem0 = RMW'(pr3 >> (V + 1));
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RMW-1:0] rs_sq;
    logic [RMW-1:0] trial;
    logic [RMW-1:0] rs_dv;
    logic [RMW-1:0] dv;
    logic [RMW-1:0] rs;
    logic [RMW-1:0] tgt;
    logic           draw;
    logic           ge;

    always_comb begin
      draw  = is_draw(sk[k]);
      rs_sq = {srem[k][RMW-3:0], ssrc[k][PW-1 -: 2]};
      trial = {sroot[k], 2'b01};
      rs_dv = {srem[k][RMW-2:0], ssrc[k][PW-1]};
      dv    = RMW'((sk[k] == K_D_FALL) ? fall : rise);
      rs    = draw ? rs_sq : rs_dv;
      tgt   = draw ? trial : dv;
      ge    = (rs >= tgt);
    end

    assign nrem[k]  = ge ? rs - tgt : rs;
    assign nroot[k] = {sroot[k][RW-2:0], ge};
    assign nsrc[k]  = draw ? (ssrc[k] << 2) : (ssrc[k] << 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      sv <= '0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      sv <= {sv[RW-1:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1  <= in_kind;
      pl1 <= in_xop[H-1:0] * y1;
      ph1 <= in_xop[XW-1:H] * y1;
      k2  <= k1;
      pr2 <= PR'(pl1) + (PR'(ph1) << H);
      k3  <= k2;
      pr3 <= pr2;
      p2l <= scale2 * q2[QH-1:0];
      p2h <= scale2 * q2[SW-1:QH];
      sk[0]    <= k3;
      saux[0]  <= aux0;
      ssrc[0]  <= src0;
      srem[0]  <= rem0;
      sroot[0] <= '0;
      for (int k = 0; k < RW; k++) begin
        sk[k+1]    <= sk[k];
        saux[k+1]  <= saux[k];
        ssrc[k+1]  <= nsrc[k];
        srem[k+1]  <= nrem[k];
        sroot[k+1] <= nroot[k];
      end
    end
  end

  always_comb begin
    off_r      = (sroot[RW] > RW'(rise)) ? rise : sroot[RW][V-1:0];
    off_f      = (sroot[RW] > RW'(fall)) ? fall : sroot[RW][V-1:0];
    out_value  = '0;
    out_region = REG_OUTSIDE;
    out_bad    = 1'b0;
    case (sk[RW])
      K_S_RISE: begin
        out_value  = corner_a + off_r;
        out_region = REG_RISE;
      end
      K_S_PLAT: begin
        out_value  = corner_a + saux[RW];
        out_region = REG_PLATEAU;
      end
      K_S_FALL: begin
        out_value  = corner_d - off_f;
        out_region = REG_FALL;
      end
      K_D_RISE: begin
        out_value  = sroot[RW][V-1:0];
        out_region = REG_RISE;
      end
      K_D_PLAT: begin
        out_value  = V'(height);
        out_region = REG_PLATEAU;
      end
      K_D_FALL: begin
        out_value  = sroot[RW][V-1:0];
        out_region = REG_FALL;
      end
      K_BAD: out_bad = 1'b1;
      default: out_bad = 1'b0;
    endcase
  end

  assign out_push = adv && sv[RW];
endmodule

// ===== rtl/core/tvs_checker.sv =====
// port-level checks for the trapezoid variate sampler, bound to the top level
// depends on tvs_pkg and trapezoid_variate_sampler_unit
module tvs_checker import tvs_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic                   write_enable,
  input logic [VALUE_WIDTH-1:0] result_value,
  input logic [1:0]             region,
  input logic                   corners_bad
);
  // derived constants are rebuilt after reset and after any write
  a_reset_blocks : assert property (@(posedge clk) rst |=> full)
    else $error("input side open right after reset");

  a_write_blocks : assert property (@(posedge clk) disable iff (rst)
    write_enable |=> full)
    else $error("input side open right after a register write");

  a_bad_is_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && corners_bad) |-> (region == REG_OUTSIDE && result_value == '0))
    else $error("unordered corners gave a nonzero result");

  a_outside_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && region == REG_OUTSIDE) |-> (result_value == '0))
    else $error("outside region with nonzero value");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result_value) && $stable(region)))
    else $error("waiting result changed or vanished");
endmodule

bind trapezoid_variate_sampler_unit tvs_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tvs_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .write_enable (write_enable),
  .result_value (result_value),
  .region       (region),
  .corners_bad  (corners_bad)
);

// ===== bench/tvs_result_checker.sv =====
// result checker for the trapezoid variate sampler: mirrors the corner registers,
// predicts each result and compares it with what the block hands out
// depends on tvs_pkg
module tvs_result_checker import tvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic        operation,
  input  logic [31:0] uniform_fraction,
  input  logic [31:0] query_point,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] result_value,
  input  logic [1:0]  region,
  input  logic        corners_bad,
  input  logic        write_enable,
  input  logic [1:0]  register_index,
  input  logic [31:0] write_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  reg_code;
    logic        bad;
  } sample_t;

  sample_t     sample_q[$];
  logic [31:0] corner[4];
  longint      ca, cb, cc, cd;
  logic        ordered;
  logic [63:0] height, low_thr, high_thr, rise_w, fall_w, span;

  function automatic logic [63:0] root_of_product(logic [63:0] x, logic [63:0] y);
    logic [127:0] prod;
    logic [127:0] sq;
    logic [63:0]  res;
    logic [63:0]  cand;
    prod = 128'(x) * 128'(y);
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      sq = 128'(cand) * 128'(cand);
      if (sq <= prod) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] scaled(logic [63:0] u, logic [63:0] s);
    logic [127:0] p;
    p = 128'(u) * 128'(s);
    return p[95:32];
  endfunction

  function automatic logic [63:0] as_fraction(logic [63:0] n, logic [63:0] s);
    logic [127:0] p;
    p = 128'(n) << 32;
    return 64'(p / 128'(s));
  endfunction

  function void rederive();
    ca = longint'($signed(corner[0]));
    cb = longint'($signed(corner[1]));
    cc = longint'($signed(corner[2]));
    cd = longint'($signed(corner[3]));
    ordered = (ca <= cb) && (cb <= cc) && (cc <= cd);
    if (!ordered) return;
    rise_w = 64'(cb - ca);
    fall_w = 64'(cd - cc);
    span = rise_w + fall_w + 2 * 64'(cc - cb);
    if (span == 0) begin
      height = 64'h7fff_ffff;
      low_thr = 0;
      high_thr = 64'd1 << 32;
    end else begin
      height = (64'd1 << 33) / span;
      if (height > 64'h7fff_ffff) height = 64'h7fff_ffff;
      low_thr = as_fraction(rise_w, span);
      high_thr = as_fraction(span - fall_w, span);
    end
  endfunction

  function automatic sample_t predict(logic op, logic [31:0] u, logic [31:0] xr);
    sample_t r;
    longint x, v;
    logic [63:0] q, off;
    x = longint'($signed(xr));
    r.bad = 0;
    v = 0;
    r.reg_code = REG_OUTSIDE;
    if (!ordered) begin
      r.bad = 1;
    end else if (op == OP_DRAW) begin
      if (64'(u) < low_thr) begin
        q = scaled(64'(u), span);
        off = root_of_product(rise_w, q);
        if (off > rise_w) off = rise_w;
        v = ca + longint'(off);
        r.reg_code = REG_RISE;
      end else if (64'(u) < high_thr) begin
        q = scaled(64'(u), span);
        off = (rise_w + q) >> 1;
        if (off > 64'(cd - ca)) off = 64'(cd - ca);
        v = ca + longint'(off);
        r.reg_code = REG_PLATEAU;
      end else begin
        q = scaled((64'd1 << 32) - 64'(u), span);
        off = root_of_product(fall_w, q);
        if (off > fall_w) off = fall_w;
        v = cd - longint'(off);
        r.reg_code = REG_FALL;
      end
    end else begin
      if (x < ca) begin
        r.reg_code = REG_OUTSIDE;
      end else if (x < cb) begin
        v = longint'(height * 64'(x - ca) / rise_w);
        r.reg_code = REG_RISE;
      end else if (x < cc) begin
        v = longint'(height);
        r.reg_code = REG_PLATEAU;
      end else if (x < cd) begin
        v = longint'(height * 64'(cd - x) / fall_w);
        r.reg_code = REG_FALL;
      end
    end
    r.value = v[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      corner[0] = 32'd0;
      corner[1] = 32'd16384;
      corner[2] = 32'd49152;
      corner[3] = 32'd65536;
      rederive();
      sample_q.delete();
      fail_count <= 0;
    end else begin
      if (write_enable) begin
        corner[register_index] = write_data;
        rederive();
      end
      if (push && !full) sample_q = {sample_q, predict(operation, uniform_fraction, query_point)};
      if (pop && !empty) begin
        if (sample_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = sample_q.pop_front();
          if (result_value !== want.value || region !== want.reg_code
              || corners_bad !== want.bad) begin
            fail_count <= fail_count + 1;
            if (result_value !== want.value)
              $error("result_value: expected %0d got %0d",
                     $signed(want.value), $signed(result_value));
            if (region !== want.reg_code)
              $error("region: expected %0d got %0d", want.reg_code, region);
            if (corners_bad !== want.bad)
              $error("corners_bad: expected %0d got %0d", want.bad, corners_bad);
          end
        end
      end
    end
    pending <= sample_q.size();
  end

endmodule

// ===== bench/tb_trapezoid_variate_sampler_unit.sv =====
// testbench top for the trapezoid variate sampler: clock, reset, stimulus and verdict
// depends on tvs_pkg, trapezoid_variate_sampler_unit and tvs_result_checker
module tb_trapezoid_variate_sampler_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tvs_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic        operation = OP_DRAW;
  logic [31:0] uniform_fraction = '0;
  logic [31:0] query_point = '0;
  logic        empty;
  logic        pop = 0;
  logic [31:0] result_value;
  logic [1:0]  region;
  logic        corners_bad;
  logic        write_enable = 0;
  logic [1:0]  register_index = IDX_CORNER_LOW;
  logic [31:0] write_data = '0;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  logic        long_hold = 0;
  logic        no_gaps = 0;
  logic        done = 0;
  logic [31:0] cur[4];

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  trapezoid_variate_sampler_unit u_dut (
    .clk, .rst, .push, .full, .operation, .uniform_fraction, .query_point,
    .empty, .pop, .result_value, .region, .corners_bad,
    .write_enable, .register_index, .write_data
  );

  tvs_result_checker u_chk (
    .clk, .rst, .push, .full, .operation, .uniform_fraction, .query_point,
    .empty, .pop, .result_value, .region, .corners_bad,
    .write_enable, .register_index, .write_data, .fail_count, .pending
  );

  // no transfer for too long means the block hung
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || write_enable || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_trapezoid_variate_sampler_unit NOT OK");
      $finish;
    end
  end

  // result side
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (long_hold) begin
        pop <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
        pop <= 1;
      end else if (gap > 0) begin
        pop <= 0;
        repeat (gap) @(posedge clk);
        pop <= 1;
      end else begin
        pop <= 1;
      end
      do @(posedge clk); while (empty);
    end
  end

  task automatic write_corner(reg_index_t idx, logic [31:0] val);
    while (full) @(posedge clk);
    write_enable <= 1;
    register_index <= idx;
    write_data <= val;
    cur[idx] = val;
    @(posedge clk);
    write_enable <= 0;
    repeat (3) @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic set_corners(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
    write_corner(IDX_CORNER_LOW, a);
    write_corner(IDX_CORNER_RISE_END, b);
    write_corner(IDX_CORNER_FALL_START, c);
    write_corner(IDX_CORNER_HIGH, d);
  endtask

  task automatic send_item(logic op, logic [31:0] u, logic [31:0] x);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    uniform_fraction <= u;
    query_point <= x;
    push <= 1;
    do @(posedge clk); while (full);
  endtask

  // sender pauses until every transfer has been checked
  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic directed_set();
    send_item(OP_DRAW, 32'h0, $urandom);
    send_item(OP_DRAW, 32'hffff_ffff, $urandom);
    send_item(OP_DRAW, 32'h8000_0000, $urandom);
    send_item(OP_DRAW, 32'h2000_0000, $urandom);
    send_item(OP_DENSITY, $urandom, cur[0]);
    send_item(OP_DENSITY, $urandom, cur[1]);
    send_item(OP_DENSITY, $urandom, cur[2]);
    send_item(OP_DENSITY, $urandom, cur[3]);
    send_item(OP_DENSITY, $urandom, cur[0] - 1);
    send_item(OP_DENSITY, $urandom, 32'h8000_0000);
    send_item(OP_DENSITY, $urandom, 32'h7fff_ffff);
    drain();
  endtask

  function automatic logic [31:0] pick_u();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_x();
    logic [31:0] near;
    near = cur[$urandom_range(0, 3)];
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return near;
      2: return near + $urandom_range(0, 3) - 2;
      default: return near + $signed(32'($urandom_range(0, 2000)) - 32'sd1000) * 64;
    endcase
  endfunction

  task automatic random_corners();
    logic [31:0] v[4];
    logic [31:0] t;
    int shift;
    shift = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(4, 30);
    for (int i = 0; i < 4; i++) begin
      v[i] = $urandom;
      if (shift != 0) v[i] = 32'($signed(v[i]) >>> (31 - shift));
    end
    if ($urandom_range(0, 3) == 0) v[1] = v[0];
    if ($urandom_range(0, 3) == 0) v[3] = v[2];
    // sort unless the phase is meant to have unordered corners
    if ($urandom_range(0, 7) != 0)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3 - i; j++)
          if ($signed(v[j]) > $signed(v[j+1])) begin
            t = v[j];
            v[j] = v[j+1];
            v[j+1] = t;
          end
    set_corners(v[0], v[1], v[2], v[3]);
  endtask

  initial begin
    cur[0] = 32'd0;
    cur[1] = 32'd16384;
    cur[2] = 32'd49152;
    cur[3] = 32'd65536;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_set();
    set_corners(32'h8000_0000, 32'hfff0_0000, 32'h0010_0000, 32'h7fff_ffff);
    directed_set();
    // tiny span so the plateau height saturates
    set_corners(32'd0, 32'd1, 32'd2, 32'd3);
    directed_set();
    set_corners(32'd0, 32'd0, 32'h0001_0000, 32'h0002_0000);
    directed_set();
    set_corners(32'hffff_0000, 32'd0, 32'h0003_0000, 32'h0003_0000);
    directed_set();
    set_corners(32'h0001_8000, 32'h0001_8000, 32'h0001_8000, 32'h0001_8000);
    directed_set();
    set_corners(32'h0005_0000, 32'd0, 32'h0001_0000, 32'h0002_0000);
    directed_set();

    for (int phase = 0; phase < 10; phase++) begin
      random_corners();
      no_gaps = (phase % 4 == 1);
      if (phase == 2) long_hold = 1;
      for (int n = 0; n < 90; n++) send_item($urandom_range(0, 1), pick_u(), pick_x());
      drain();
    end
    no_gaps = 0;
    done = 1;
  end

  initial begin
    wait (done);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_trapezoid_variate_sampler_unit OK");
    end else begin
      $display("tb_trapezoid_variate_sampler_unit NOT OK");
    end
    $finish;
  end

endmodule
